// File: src/jse_pkg.sv
package jse_pkg;

	localparam int unsigned CpW     = 21;
	localparam int unsigned MaxLen  = 12;
	localparam int unsigned LenW    = 4;

	typedef logic [CpW-1:0]       cp_t;
	typedef logic [LenW-1:0]      len_t;
	typedef logic [7:0]           byte_t;
	typedef logic [5:0][7:0]      u16_esc_t;

	// Index 15 holds '0' because a string literal fills a packed array from the top.
	localparam logic [15:0][7:0] HexDigits = "0123456789abcdef";

	localparam byte_t CHAR_QUOTE  = 8'h22;
	localparam byte_t CHAR_BSLASH = 8'h5C;
	localparam byte_t CHAR_U      = 8'h75;
	localparam byte_t CHAR_N      = 8'h6E;
	localparam byte_t CHAR_R      = 8'h72;
	localparam byte_t CHAR_T      = 8'h74;
	localparam byte_t CHAR_B      = 8'h62;
	localparam byte_t CHAR_F      = 8'h66;
	localparam byte_t CHAR_SPACE  = 8'h20;
	localparam byte_t CHAR_TILDE  = 8'h7E;

	localparam cp_t CP_NUL      = 21'h000000;
	localparam cp_t CP_BS       = 21'h000008;
	localparam cp_t CP_TAB      = 21'h000009;
	localparam cp_t CP_LF       = 21'h00000A;
	localparam cp_t CP_FF       = 21'h00000C;
	localparam cp_t CP_CR       = 21'h00000D;
	localparam cp_t CP_QUOTE    = 21'h000022;
	localparam cp_t CP_BSLASH   = 21'h00005C;
	localparam cp_t CP_LAST_CTL = 21'h00001F;
	localparam cp_t CP_DEL      = 21'h00007F;
	localparam cp_t CP_SUPP     = 21'h010000;
	localparam cp_t CP_MAX      = 21'h10FFFF;

	localparam logic [15:0] REPLACEMENT = 16'hFFFD;
	localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
	localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

	typedef struct packed {
		len_t                    len;
		logic [MaxLen-1:0][7:0]  bytes;
	} desc_t;

	function automatic byte_t hex_digit(input logic [3:0] n);
		return HexDigits[~n];
	endfunction

	function automatic u16_esc_t u16_escape(input logic [15:0] v);
		u16_esc_t res;
		res[0] = CHAR_BSLASH;
		res[1] = CHAR_U;
		res[2] = hex_digit(v[15:12]);
		res[3] = hex_digit(v[11:8]);
		res[4] = hex_digit(v[7:4]);
		res[5] = hex_digit(v[3:0]);
		return res;
	endfunction

endpackage

// File: src/jse_item_if.sv
interface jse_item_if;
	logic          valid;
	logic          ready;
	logic          func;
	jse_pkg::cp_t  codepoint;

	modport source (output valid, output func, output codepoint, input ready);
	modport sink   (input valid, input func, input codepoint, output ready);
endinterface

// File: src/jse_byte_if.sv
interface jse_byte_if;
	logic           valid;
	logic           ready;
	jse_pkg::byte_t out_byte;
	logic           last_byte;

	modport source (output valid, output out_byte, output last_byte, input ready);
	modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// File: src/jse_encode.sv
module jse_encode (
	input  logic           func,
	input  jse_pkg::cp_t   codepoint,
	output jse_pkg::desc_t desc
);

	logic [19:0] supp_off;

	assign supp_off = 20'(codepoint - jse_pkg::CP_SUPP);

	always_comb begin
		desc.len   = '0;
		desc.bytes = '0;
		priority if (func) begin
			desc.len      = jse_pkg::len_t'(1);
			desc.bytes[0] = jse_pkg::CHAR_QUOTE;
		end else if (codepoint == jse_pkg::CP_NUL) begin
			desc.len = '0;
		end else if (codepoint == jse_pkg::CP_QUOTE) begin
			desc.len      = jse_pkg::len_t'(2);
			desc.bytes[0] = jse_pkg::CHAR_BSLASH;
			desc.bytes[1] = jse_pkg::CHAR_QUOTE;
		end else if (codepoint == jse_pkg::CP_BSLASH) begin
			desc.len      = jse_pkg::len_t'(2);
			desc.bytes[0] = jse_pkg::CHAR_BSLASH;
			desc.bytes[1] = jse_pkg::CHAR_BSLASH;
		end else if (codepoint == jse_pkg::CP_LF) begin
			desc.len      = jse_pkg::len_t'(2);
			desc.bytes[0] = jse_pkg::CHAR_BSLASH;
			desc.bytes[1] = jse_pkg::CHAR_N;
		end else if (codepoint == jse_pkg::CP_CR) begin
			desc.len      = jse_pkg::len_t'(2);
			desc.bytes[0] = jse_pkg::CHAR_BSLASH;
			desc.bytes[1] = jse_pkg::CHAR_R;
		end else if (codepoint == jse_pkg::CP_TAB) begin
			desc.len      = jse_pkg::len_t'(2);
			desc.bytes[0] = jse_pkg::CHAR_BSLASH;
			desc.bytes[1] = jse_pkg::CHAR_T;
		end else if (codepoint == jse_pkg::CP_BS) begin
			desc.len      = jse_pkg::len_t'(2);
			desc.bytes[0] = jse_pkg::CHAR_BSLASH;
			desc.bytes[1] = jse_pkg::CHAR_B;
		end else if (codepoint == jse_pkg::CP_FF) begin
			desc.len      = jse_pkg::len_t'(2);
			desc.bytes[0] = jse_pkg::CHAR_BSLASH;
			desc.bytes[1] = jse_pkg::CHAR_F;
		end else if (codepoint > jse_pkg::CP_LAST_CTL && codepoint < jse_pkg::CP_DEL) begin
			desc.len      = jse_pkg::len_t'(1);
			desc.bytes[0] = codepoint[7:0];
		end else if (codepoint < jse_pkg::CP_SUPP) begin
			desc.len        = jse_pkg::len_t'(6);
			desc.bytes[5:0] = jse_pkg::u16_escape(codepoint[15:0]);
		end else if (codepoint <= jse_pkg::CP_MAX) begin
			// Supplementary planes go out as a high/low surrogate pair.
			desc.len         = jse_pkg::len_t'(12);
			desc.bytes[5:0]  = jse_pkg::u16_escape({jse_pkg::HI_SURR_TAG, supp_off[19:10]});
			desc.bytes[11:6] = jse_pkg::u16_escape({jse_pkg::LO_SURR_TAG, supp_off[9:0]});
		end else begin
			desc.len        = jse_pkg::len_t'(6);
			desc.bytes[5:0] = jse_pkg::u16_escape(jse_pkg::REPLACEMENT);
		end
	end

endmodule

// File: src/jse_emit.sv
module jse_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  jse_pkg::desc_t desc,
	output logic           free,
	jse_byte_if.source     text
);

	jse_pkg::len_t                           cnt_q;
	logic [jse_pkg::MaxLen-1:0][7:0]         bytes_q;
	logic                                    take;

	assign take = text.valid && text.ready;
	// Free when empty, or when the final byte of the current item leaves this cycle.
	assign free = (cnt_q == '0) || (take && cnt_q == jse_pkg::len_t'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= desc.len;
		end else if (take) begin
			cnt_q <= cnt_q - jse_pkg::len_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= desc.bytes;
		end else if (take) begin
			bytes_q <= bytes_q >> 8;
		end
	end

	assign text.valid     = (cnt_q != '0);
	assign text.out_byte  = bytes_q[0];
	assign text.last_byte = (cnt_q == jse_pkg::len_t'(1));

endmodule

// File: src/json_string_escape_core.sv
// JSON string escaper.
// The item channel takes one word per item: func high asks for a string
// delimiter quote, func low asks for the escaped form of codepoint. The text
// channel returns the escaped bytes one word at a time, with last_byte set on
// the final byte of each item. Codepoint zero produces no bytes at all.
// The first byte of an item is offered on the text channel once the item has
// passed the input register and been loaded into the output shift register.
// Throughput: one item per cycle while each item yields one byte, as plain
// printable ASCII does, and the receiver does not stall. An item of n bytes
// (2, 6 or 12) holds the output shift register until its last byte is taken,
// and the item register takes the next word as soon as the current one moves
// on, so an item producing nothing is retired without waiting for the output.
// When the receiver stalls, the current byte holds, the item register fills,
// and item ready drops until the output frees up.
// Reset empties both registers; there is no setup or clearing phase after it.
module json_string_escape_core (
	input  logic       clk,
	input  logic       arst_n,
	jse_item_if.sink   item,
	jse_byte_if.source text
);

	logic           valid_s1;
	logic           func_s1;
	jse_pkg::cp_t   codepoint_s1;
	jse_pkg::desc_t desc;
	logic           emit_free;
	logic           adv_s1;
	logic           load;

	assign adv_s1     = valid_s1 && (desc.len == '0 || emit_free);
	assign load       = valid_s1 && desc.len != '0 && emit_free;
	assign item.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			func_s1      <= item.func;
			codepoint_s1 <= item.codepoint;
		end
	end

	jse_encode u_encode (
		.func      (func_s1),
		.codepoint (codepoint_s1),
		.desc      (desc)
	);

	jse_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.desc   (desc),
		.free   (emit_free),
		.text   (text)
	);

endmodule

// File: src/jse_checker.sv
module jse_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           text_valid,
	input logic           text_ready,
	input jse_pkg::byte_t out_byte,
	input logic           last_byte
);

	// Nothing is offered while reset is held.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !text_valid)
		else $error("text valid during reset");

	// Escaped JSON text is printable ASCII only.
	a_printable: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid |-> (out_byte >= jse_pkg::CHAR_SPACE && out_byte <= jse_pkg::CHAR_TILDE))
		else $error("non-printable byte on text channel");

	// A quote is either a delimiter or the tail of an escape, so it always ends an item.
	a_quote_last: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && out_byte == jse_pkg::CHAR_QUOTE |-> last_byte)
		else $error("quote byte not marked last");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_ready |=>
			text_valid && $stable(out_byte) && $stable(last_byte))
		else $error("text word changed while stalled");

endmodule

bind json_string_escape_core jse_checker u_jse_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.text_valid (text.valid),
	.text_ready (text.ready),
	.out_byte   (text.out_byte),
	.last_byte  (text.last_byte)
);
